// File: rtl/core/inversion_parity_checker_macros.svh
// Assertion macros for the inversion parity checker.
`ifndef INVERSION_PARITY_CHECKER_MACROS_SVH
`define INVERSION_PARITY_CHECKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define IPC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("inversion parity checker: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define IPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("inversion parity checker: next-cycle check failed");

`endif

// File: rtl/core/ipc_pkg.sv
package ipc_pkg;

	localparam int VALUE_BITS    = 32;
	localparam int MAX_ITEMS_DEF = 512;

	localparam logic [VALUE_BITS-1:0] SIGN_MASK = {1'b1, {(VALUE_BITS-1){1'b0}}};

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic                         last_item;
	} in_t;

	typedef struct packed {
		logic sortable;
		logic had_duplicate;
		logic odd_inversions;
		logic overflowed;
	} out_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_end;
		logic last;
		out_t res;
	} st_t;

endpackage

// File: rtl/core/ipc_dp.sv
module ipc_dp #(
	parameter int MAX_ITEMS = ipc_pkg::MAX_ITEMS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ipc_pkg::in_t  item,
	input  ipc_pkg::cmd_t cmd,
	output ipc_pkg::st_t  st
);
	import ipc_pkg::*;

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

	logic [VALUE_BITS-1:0] mem [MAX_ITEMS];

	logic [VALUE_BITS-1:0] key;
	logic [VALUE_BITS-1:0] key_q;
	logic                  last_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         lim_q;
	logic [CW-1:0]         rd_cnt_q;
	logic                  rvld_s1;
	logic [VALUE_BITS-1:0] rdata_s1;
	logic                  par_q;
	logic                  dup_q;
	logic                  ovf_q;
	logic                  full;

	assign key  = VALUE_BITS'(item.value) ^ SIGN_MASK;
	assign full = (cnt_q == MAX_CNT);

	// store the new word behind the ones it is scanned against
	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			mem[cnt_q[AW-1:0]] <= key;
		end
		if (cmd.rd) begin
			rdata_s1 <= mem[rd_cnt_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= key;
			last_q <= item.last_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			lim_q    <= '0;
			rd_cnt_q <= '0;
			rvld_s1  <= 1'b0;
			par_q    <= 1'b0;
			dup_q    <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			rvld_s1 <= cmd.rd;
			if (cmd.load) begin
				lim_q    <= cnt_q;
				rd_cnt_q <= '0;
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (cmd.rd) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (cmd.finish) begin
				cnt_q <= '0;
				par_q <= 1'b0;
				dup_q <= 1'b0;
				ovf_q <= 1'b0;
			end else if (rvld_s1) begin
				if (rdata_s1 > key_q) begin
					par_q <= ~par_q;
				end else if (rdata_s1 == key_q) begin
					dup_q <= 1'b1;
				end
			end
		end
	end

	assign st.scan_end           = (rd_cnt_q == lim_q);
	assign st.last               = last_q;
	assign st.res.sortable       = dup_q | ~par_q;
	assign st.res.had_duplicate  = dup_q;
	assign st.res.odd_inversions = par_q;
	assign st.res.overflowed     = ovf_q;

endmodule

// File: rtl/core/ipc_ctrl.sv
module ipc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          out_free,
	input  ipc_pkg::st_t  st,
	output ipc_pkg::cmd_t cmd,
	output logic          busy
);
	import ipc_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy       = (state_q != S_IDLE);
	assign cmd.load   = (state_q == S_IDLE) && item_valid;
	assign cmd.rd     = (state_q == S_SCAN) && !st.scan_end;
	assign cmd.finish = (state_q == S_DONE) && st.last && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.scan_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!st.last || out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/inversion_parity_checker.sv
// Inversion parity checker.
// Input channel item (item_valid / item_stall) carries one signed value and a
// last_item flag per word. Each value is compared with every value stored
// earlier in the sequence and then stored, up to MAX_ITEMS values.
// Output channel result (result_valid / result_stall) carries one word per
// sequence, sent after the word with last_item set: sortable, had_duplicate,
// odd_inversions and overflowed. Non-last words give no result.
// Timing: a word is taken only once the scan for the word before it is through;
// the scan reads the value memory one entry per cycle through its single read
// port, comparing the word with each stored value in turn. result_valid rises
// from the output register once the scan of the last word is done.
// The result sits in an output register; a stalled result holds there while
// the next sequence is taken in. A further result waits until it is taken.
// Reset clears the count and flags; the memory needs no clearing, so words
// are accepted from the first cycle after reset.
module inversion_parity_checker #(
	parameter int MAX_ITEMS = ipc_pkg::MAX_ITEMS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  ipc_pkg::in_t  item,
	output logic          result_valid,
	input  logic          result_stall,
	output ipc_pkg::out_t result
);
	import ipc_pkg::*;

	cmd_t cmd;
	st_t  st;
	logic out_free;
	logic result_valid_q;
	out_t result_q;

	assign out_free = !result_valid_q || !result_stall;

	ipc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.out_free   (out_free),
		.st         (st),
		.cmd        (cmd),
		.busy       (item_stall)
	);

	ipc_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.st     (st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q <= st.res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: rtl/core/ipc_checker.sv
`include "inversion_parity_checker_macros.svh"

module ipc_props (
	input logic          clk,
	input logic          arst_n,
	input logic          item_valid,
	input logic          item_stall,
	input logic          result_valid,
	input logic          result_stall,
	input ipc_pkg::out_t result
);
	import ipc_pkg::*;

	logic sort_ok;

	assign sort_ok = result.had_duplicate || !result.odd_inversions;

	`IPC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
	`IPC_ASSERT_NOW(a_sortable_rule, result_valid, result.sortable == sort_ok)
	`IPC_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)
	`IPC_ASSERT_NOW(a_result_after_work, $rose(result_valid), $past(item_stall))

endmodule

bind inversion_parity_checker ipc_props u_ipc_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// File: test/ipc_checker.sv
module ipc_checker #(
	parameter int DEPTH = ipc_pkg::MAX_ITEMS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          item_stall,
	input  ipc_pkg::in_t  item,
	input  logic          result_valid,
	input  logic          result_stall,
	input  ipc_pkg::out_t result,
	output int            fails,
	output int            pending
);
	import ipc_pkg::*;

	logic signed [VALUE_BITS-1:0] kept_vals [DEPTH];
	int unsigned kept_count = 0;
	logic odd_par = 1'b0;
	logic dup_seen = 1'b0;
	logic ovf_seen = 1'b0;
	out_t verdicts_due [$];
	int fail_total = 0;
	int shown = 0;

	// Fold one word into the running parity, duplicate and overflow state; a last word queues the expected verdict.
	task automatic take_word(input in_t w);
		logic signed [VALUE_BITS-1:0] x;
		int unsigned n;
		out_t v;
		x = w.value;
		n = kept_count;
		for (int unsigned i = 0; i < n; i++) begin
			if (kept_vals[i] > x)
				odd_par = !odd_par;
			else if (kept_vals[i] == x)
				dup_seen = 1'b1;
		end
		if (n < DEPTH) begin
			kept_vals[n] = x;
			kept_count = n + 1;
		end else begin
			ovf_seen = 1'b1;
		end
		if (w.last_item) begin
			v.sortable = dup_seen || !odd_par;
			v.had_duplicate = dup_seen;
			v.odd_inversions = odd_par;
			v.overflowed = ovf_seen;
			verdicts_due = {verdicts_due, v};
			kept_count = 0;
			odd_par = 1'b0;
			dup_seen = 1'b0;
			ovf_seen = 1'b0;
		end
	endtask

	task automatic check_verdict(input out_t got);
		out_t want;
		logic bad;
		if (verdicts_due.size() == 0) begin
			fail_total++;
			if (shown < 10)
				$display("unexpected result word: sortable=%0b dup=%0b odd=%0b ovf=%0b",
					got.sortable, got.had_duplicate, got.odd_inversions, got.overflowed);
			shown++;
		end else begin
			want = verdicts_due.pop_front();
			bad = (got !== want);
			if (bad) begin
				fail_total++;
				if (shown < 10)
					$display("mismatch: expected sdov=%b%b%b%b got sdov=%b%b%b%b",
						want.sortable, want.had_duplicate, want.odd_inversions,
						want.overflowed, got.sortable, got.had_duplicate,
						got.odd_inversions, got.overflowed);
				shown++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				check_verdict(result);
			if (item_valid && !item_stall)
				take_word(item);
			fails <= fail_total;
			pending <= verdicts_due.size();
		end
	end

endmodule

// File: test/tb_inversion_parity_checker.sv
module tb_inversion_parity_checker;
	import ipc_pkg::*;

	localparam int DEPTH = MAX_ITEMS_DEF;
	localparam int TOTAL_WORDS = 1160;
	localparam int QUIET_LIMIT = 4 * (DEPTH + 24);
	localparam logic signed [VALUE_BITS-1:0] V_MIN = SIGN_MASK;
	localparam logic signed [VALUE_BITS-1:0] V_MAX = ~SIGN_MASK;

	typedef enum int {FILL_WIDE, FILL_NARROW, FILL_PERM, FILL_EDGES} fill_e;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic result_stall = 1'b0;
	in_t item = '0;
	logic item_stall;
	logic result_valid;
	out_t result;
	int fails;
	int pending;
	int quiet_cycles = 0;
	int stall_left = 0;
	int words_sent = 0;
	bit steady_words = 1'b0;
	bit steady_results = 1'b0;
	logic signed [VALUE_BITS-1:0] seq_vals [$];

	inversion_parity_checker #(.MAX_ITEMS(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	ipc_checker #(.DEPTH(DEPTH)) watch (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.fails(fails),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if ($urandom_range(0, 4) == 0)
				steady_results = !steady_results;
			stall_left = steady_results ? 0 : $urandom_range(0, 5);
		end else if (stall_left != 0) begin
			stall_left = stall_left - 1;
		end
		result_stall <= (stall_left != 0);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_word(input logic signed [VALUE_BITS-1:0] v, input logic last);
		int gap;
		gap = steady_words ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{value: v, last_item: last};
		do @(posedge clk); while (item_stall);
		words_sent++;
	endtask

	task automatic send_seq();
		for (int i = 0; i < seq_vals.size(); i++)
			send_word(seq_vals[i], i == seq_vals.size() - 1);
		seq_vals.delete();
	endtask

	task automatic add_val(input logic signed [VALUE_BITS-1:0] v);
		seq_vals = {seq_vals, v};
	endtask

	task automatic build_seq(input int len, input fill_e mode);
		int order [$];
		int j;
		int tmp;
		logic [VALUE_BITS-1:0] base;
		int unsigned stride;
		base = $urandom;
		stride = $urandom_range(1, 1000);
		for (int i = 0; i < len; i++)
			order = {order, i};
		for (int i = len - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < len; i++) begin
			case (mode)
				FILL_WIDE: add_val($urandom);
				FILL_NARROW: add_val($urandom_range(0, 6) - 3);
				FILL_PERM: add_val(base + order[i] * stride);
				default: begin
					case ($urandom_range(0, 6))
						0: add_val(V_MIN);
						1: add_val(V_MAX);
						2: add_val(0);
						3: add_val(-1);
						4: add_val(1);
						5: add_val(V_MIN + 1);
						default: add_val(V_MAX - 1);
					endcase
				end
			endcase
		end
	endtask

	initial begin
		int len;
		int ovf_at;
		bit ovf_done;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		seq_vals = '{V_MIN};
		send_seq();
		seq_vals = '{V_MAX};
		send_seq();
		seq_vals = '{V_MAX, V_MIN};
		send_seq();
		seq_vals = '{5, 5};
		send_seq();
		seq_vals = '{-1, 0};
		send_seq();
		seq_vals = '{0, -1};
		send_seq();
		seq_vals = '{3, 2, 1};
		send_seq();
		seq_vals = '{V_MIN, V_MAX, 0, -1};
		send_seq();
		seq_vals = '{7, 9, 7, 1};
		send_seq();

		ovf_at = $urandom_range(100, 500);
		ovf_done = 1'b0;
		while (words_sent < TOTAL_WORDS) begin
			steady_words = ($urandom_range(0, 3) == 0);
			if (!ovf_done && words_sent >= ovf_at) begin
				len = DEPTH + 1 + $urandom_range(0, 2);
				ovf_done = 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				len = $urandom_range(13, 40);
			end else begin
				len = $urandom_range(1, 12);
			end
			build_seq(len, fill_e'($urandom_range(0, 3)));
			send_seq();
		end
		item_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DEPTH + 4) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
